// ----- rtl/elevation_color_ramp_defines.svh -----
// Assertion macros shared by the elevation color ramp RTL.
// Expects clk and rst_n to be visible where a macro is used.
`ifndef ELEVATION_COLOR_RAMP_DEFINES_SVH
`define ELEVATION_COLOR_RAMP_DEFINES_SVH

// Same-cycle implication, off while reset is held.
`define ECR_CHECK_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("elevation_color_ramp: same-cycle check failed");

// Next-cycle implication, off while reset is held.
`define ECR_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("elevation_color_ramp: next-cycle check failed");

`endif

// ----- rtl/ecr_pkg.sv -----
// Constants, register codes and shared types for the elevation color ramp.
// No dependencies; used by elevation_color_ramp.
package ecr_pkg;

  localparam int MAX_KNOTS  = 6;
  localparam int KNOT_SLOTS = 6;
  localparam int FRAC_BITS  = 8;

  localparam int CH_W      = 8;
  localparam int DZ_W      = 16;
  localparam int ELEV_FRAC = 4;
  localparam int ELEV_W    = 21;
  localparam int KNOT_W    = ELEV_W + 3 * CH_W;
  localparam int KCNT_W    = 3;
  localparam int CFG_IDX_W = 3;
  localparam int LAST_W    = $clog2(MAX_KNOTS);
  localparam int SEG_W     = $clog2(KNOT_SLOTS);
  localparam int DIFF_W    = ELEV_W + 1;
  localparam int DIV_W     = ELEV_W;

  localparam logic [CH_W:0] FLOOD_ADD  = (CH_W + 1)'(90);
  localparam logic [CH_W:0] CHAN_LIMIT = (CH_W + 1)'(255);

  localparam logic signed [DZ_W-1:0] FLOOD_BLUE_BELOW  = DZ_W'(10);
  localparam logic signed [DZ_W-1:0] FLOOD_GREEN_BELOW = DZ_W'(50);
  localparam logic signed [DZ_W-1:0] FLOOD_RED_BELOW   = DZ_W'(100);

  localparam logic [KCNT_W-1:0]      KNOT_COUNT_RESET = KCNT_W'(6);
  localparam logic signed [DZ_W-1:0] FALLBACK_RESET   = -DZ_W'(10);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KNOT_COUNT = 3'd0,
    REG_KNOT_0     = 3'd1,
    REG_KNOT_1     = 3'd2,
    REG_KNOT_2     = 3'd3,
    REG_KNOT_3     = 3'd4,
    REG_KNOT_4     = 3'd5,
    REG_KNOT_5     = 3'd6,
    REG_FALLBACK   = 3'd7
  } cfg_reg_t;

  // Channel 0 blue, 1 green, 2 red (matches knot packing).
  typedef logic [2:0][CH_W-1:0] rgb_t;

endpackage

// ----- rtl/elevation_color_ramp.sv -----
// Elevation color ramp: per pixel heat-map color and flood-tinted source pixel.
// Depends on ecr_pkg and elevation_color_ramp_defines.svh.
//
// Usage:
//   Input channel (in_valid / in_stall): one item per pixel with a signed
//   elevation, a grid flag and a BGR source pixel. Output channel
//   (out_valid / out_stall): one item per input item, ramp color plus
//   tinted source color, in input order.
//   Config channel (cfg_valid / cfg_ready): register index and data; always
//   ready. Write only while no item is in flight.
// Timing:
//   Stages: compare, knot select, clamp, one stage per quotient bit of the
//   fraction divider, and the blend multiply. Throughput is one item per
//   cycle while out_stall is low; each divider stage resolves one fraction
//   bit with one compare and subtract.
// Stall:
//   Every stage carries a valid bit; a stage advances when it is empty or its
//   successor advances, so bubbles are squeezed out and the block keeps
//   accepting items until every stage holds one. The output register holds
//   its item while out_stall is high.
// Reset:
//   rst_n (synchronous) empties the pipeline and loads register defaults:
//   six knots, all knots zero, fallback elevation -10.
`include "elevation_color_ramp_defines.svh"

module elevation_color_ramp (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // input channel
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [ecr_pkg::DZ_W-1:0]         in_elevation,
  input  logic                                    in_in_grid,
  input  logic [ecr_pkg::CH_W-1:0]                in_src_blue,
  input  logic [ecr_pkg::CH_W-1:0]                in_src_green,
  input  logic [ecr_pkg::CH_W-1:0]                in_src_red,
  // output channel
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [ecr_pkg::CH_W-1:0]                out_heat_blue,
  output logic [ecr_pkg::CH_W-1:0]                out_heat_green,
  output logic [ecr_pkg::CH_W-1:0]                out_heat_red,
  output logic [ecr_pkg::CH_W-1:0]                out_flood_blue,
  output logic [ecr_pkg::CH_W-1:0]                out_flood_green,
  output logic [ecr_pkg::CH_W-1:0]                out_flood_red,
  // configuration channel
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [ecr_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [ecr_pkg::KNOT_W-1:0]              cfg_data
);

  localparam int FB   = ecr_pkg::FRAC_BITS;
  localparam int NSTG = FB + 4;             // A, B, clamp, FB divider steps, blend
  localparam int CW   = ecr_pkg::CH_W;
  localparam int KS   = ecr_pkg::KNOT_SLOTS;
  localparam int EW   = ecr_pkg::ELEV_W;
  localparam int DW   = ecr_pkg::DIFF_W;
  localparam int VW   = ecr_pkg::DIV_W;
  localparam int PW   = CW + FB + 1;        // blend product width

  // Stage A: elevation in Q16.4, knot compares, clamped last-knot index.
  typedef struct packed {
    logic signed [EW-1:0]           z;
    logic [KS-1:0]                  lt;
    logic [ecr_pkg::LAST_W-1:0]     last;
    ecr_pkg::rgb_t                  flood;
  } stage_a_t;

  // Stage B: segment chosen, span and offset taken.
  typedef struct packed {
    logic signed [DW-1:0]           span;
    logic signed [DW-1:0]           off;
    ecr_pkg::rgb_t                  ca;
    ecr_pkg::rgb_t                  cb;
    logic                           flat;
    ecr_pkg::rgb_t                  flood;
  } stage_b_t;

  // Clamp and divider stages: restoring division, one quotient bit a stage.
  typedef struct packed {
    logic [VW-1:0]                  rem;
    logic [VW-1:0]                  dvs;
    logic [FB-1:0]                  q;
    ecr_pkg::rgb_t                  ca;
    ecr_pkg::rgb_t                  cb;
    logic                           flat;
    ecr_pkg::rgb_t                  flood;
  } div_t;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [ecr_pkg::KCNT_W-1:0]         knot_count_r;
  logic [ecr_pkg::KNOT_W-1:0]         knot_r [KS];
  logic signed [ecr_pkg::DZ_W-1:0]    fallback_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      knot_count_r <= ecr_pkg::KNOT_COUNT_RESET;
      fallback_r   <= ecr_pkg::FALLBACK_RESET;
      for (int k = 0; k < KS; k++) begin
        knot_r[k] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      priority if (cfg_index == ecr_pkg::REG_KNOT_COUNT) begin
        knot_count_r <= cfg_data[ecr_pkg::KCNT_W-1:0];
      end else if (cfg_index == ecr_pkg::REG_FALLBACK) begin
        fallback_r <= cfg_data[ecr_pkg::DZ_W-1:0];
      end else begin
        knot_r[ecr_pkg::SEG_W'(cfg_index - 1'b1)] <= cfg_data;
      end
    end
  end

  // Unpack knots: elevation in the top bits, BGR in the low 24.
  logic signed [EW-1:0] kelev [KS];
  ecr_pkg::rgb_t        kcol  [KS];

  always_comb begin
    for (int k = 0; k < KS; k++) begin
      kelev[k] = knot_r[k][ecr_pkg::KNOT_W-1 -: EW];
      kcol[k]  = knot_r[k][3*CW-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline flow control
  // ---------------------------------------------------------------------
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] rdy;

  // A stage may load when the output drains or any stage from it onward is empty.
  always_comb begin
    for (int k = 0; k < NSTG; k++) begin
      rdy[k] = !out_stall || !(&(vld_r | NSTG'((1 << k) - 1)));
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = vld_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage A: fallback select, knot compares, flood tint
  // ---------------------------------------------------------------------
  function automatic logic [CW-1:0] tint(input logic [CW-1:0] c, input logic on);
    logic [CW:0] s;
    s = {1'b0, c} + ecr_pkg::FLOOD_ADD;
    tint = (on && (s < ecr_pkg::CHAN_LIMIT)) ? s[CW-1:0] : c;
  endfunction

  stage_a_t a_nxt, a_r;

  always_comb begin
    logic signed [ecr_pkg::DZ_W-1:0] dz;
    logic tb, tg, tr;
    int   cnt;
    dz = in_in_grid ? in_elevation : fallback_r;
    // Scale meters to Q16.4 and sign-extend to the knot width.
    a_nxt.z = {{(EW - ecr_pkg::DZ_W - ecr_pkg::ELEV_FRAC){dz[ecr_pkg::DZ_W-1]}},
               dz, {ecr_pkg::ELEV_FRAC{1'b0}}};
    for (int k = 0; k < KS; k++) begin
      a_nxt.lt[k] = a_nxt.z < kelev[k];
    end
    // Clamp the knot count into 2..MAX_KNOTS.
    cnt = int'(knot_count_r);
    if (cnt < 2) begin
      cnt = 2;
    end
    if (cnt > ecr_pkg::MAX_KNOTS) begin
      cnt = ecr_pkg::MAX_KNOTS;
    end
    a_nxt.last = ecr_pkg::LAST_W'(cnt - 1);
    // Flood bands are exclusive: blue wins, then green, then red.
    tb = dz < ecr_pkg::FLOOD_BLUE_BELOW;
    tg = !tb && (dz < ecr_pkg::FLOOD_GREEN_BELOW);
    tr = !tb && !tg && (dz < ecr_pkg::FLOOD_RED_BELOW);
    a_nxt.flood[0] = tint(in_src_blue,  tb);
    a_nxt.flood[1] = tint(in_src_green, tg);
    a_nxt.flood[2] = tint(in_src_red,   tr);
  end

  // ---------------------------------------------------------------------
  // Stage B: pick segment, fetch its knots, take span and offset
  // ---------------------------------------------------------------------
  stage_b_t b_nxt, b_r;

  always_comb begin
    logic [ecr_pkg::SEG_W-1:0] pick;
    logic                      flat;
    logic signed [EW-1:0]      e0, e1;
    ecr_pkg::rgb_t             ca, cb;
    int                        nk;
    pick = '0;
    flat = 1'b0;
    if (a_r.lt[0]) begin
      // below the first knot: first color
      flat = 1'b1;
    end else if (!a_r.lt[a_r.last]) begin
      // at or above the last knot in use: last color
      pick = ecr_pkg::SEG_W'(a_r.last);
      flat = 1'b1;
    end else begin
      pick = ecr_pkg::SEG_W'(a_r.last - 1'b1);
      for (int x = KS - 2; x >= 0; x--) begin
        if ((x < int'(a_r.last)) && a_r.lt[x+1]) begin
          pick = ecr_pkg::SEG_W'(x);
        end
      end
    end
    e0 = kelev[0];
    e1 = kelev[0];
    ca = kcol[0];
    cb = kcol[0];
    nk = 0;
    for (int k = 0; k < KS; k++) begin
      nk = (k + 1 < KS) ? k + 1 : k;
      if (pick == ecr_pkg::SEG_W'(k)) begin
        e0 = kelev[k];
        ca = kcol[k];
        e1 = kelev[nk];
        cb = kcol[nk];
      end
    end
    b_nxt.span  = {e1[EW-1], e1} - {e0[EW-1], e0};
    b_nxt.off   = {a_r.z[EW-1], a_r.z} - {e0[EW-1], e0};
    b_nxt.ca    = ca;
    b_nxt.cb    = flat ? ca : cb;
    b_nxt.flat  = flat;
    b_nxt.flood = a_r.flood;
  end

  // ---------------------------------------------------------------------
  // Clamp stage: offset into [0, span-1]; non-positive span gives f = 0
  // ---------------------------------------------------------------------
  div_t c_nxt;
  div_t st_r [FB+1];

  always_comb begin
    logic                 span_pos;
    logic signed [DW-1:0] off_c;
    span_pos = !b_r.span[DW-1] && (b_r.span != '0);
    off_c    = b_r.off;
    if (off_c[DW-1]) begin
      off_c = '0;
    end
    if (span_pos && (off_c >= b_r.span)) begin
      off_c = b_r.span - DW'(1);
    end
    c_nxt.rem   = off_c[VW-1:0];
    c_nxt.dvs   = b_r.span[VW-1:0];
    c_nxt.q     = '0;
    c_nxt.ca    = b_r.ca;
    c_nxt.cb    = b_r.cb;
    c_nxt.flat  = b_r.flat || !span_pos;
    c_nxt.flood = b_r.flood;
  end

  // ---------------------------------------------------------------------
  // Divider stages: shift remainder, compare, subtract, shift in a bit
  // ---------------------------------------------------------------------
  div_t step_nxt [FB];

  always_comb begin
    logic [VW:0] r2;
    logic        ge;
    for (int j = 0; j < FB; j++) begin
      r2 = {st_r[j].rem, 1'b0};
      ge = r2 >= {1'b0, st_r[j].dvs};
      step_nxt[j]     = st_r[j];
      step_nxt[j].rem = ge ? VW'(r2 - {1'b0, st_r[j].dvs}) : r2[VW-1:0];
      step_nxt[j].q   = {st_r[j].q[FB-2:0], ge};
    end
  end

  // ---------------------------------------------------------------------
  // Blend stage: c_x * (1 - f) + c_x+1 * f, truncated
  // ---------------------------------------------------------------------
  ecr_pkg::rgb_t heat_nxt, heat_r, flood_r;

  always_comb begin
    logic [FB-1:0] f;
    logic [FB:0]   one_m;
    logic [PW-1:0] sum;
    f     = st_r[FB].flat ? '0 : st_r[FB].q;
    one_m = (FB + 1)'(1 << FB) - {1'b0, f};
    for (int c = 0; c < 3; c++) begin
      sum = PW'(st_r[FB].ca[c]) * PW'(one_m) + PW'(st_r[FB].cb[c]) * PW'(f);
      heat_nxt[c] = sum[FB +: CW];
    end
  end

  // ---------------------------------------------------------------------
  // Payload registers: load on advance, hold otherwise
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      a_r <= a_nxt;
    end
    if (rdy[1]) begin
      b_r <= b_nxt;
    end
    if (rdy[2]) begin
      st_r[0] <= c_nxt;
    end
    for (int j = 0; j < FB; j++) begin
      if (rdy[3+j]) begin
        st_r[j+1] <= step_nxt[j];
      end
    end
    if (rdy[NSTG-1]) begin
      heat_r  <= heat_nxt;
      flood_r <= st_r[FB].flood;
    end
  end

  assign out_heat_blue   = heat_r[0];
  assign out_heat_green  = heat_r[1];
  assign out_heat_red    = heat_r[2];
  assign out_flood_blue  = flood_r[0];
  assign out_flood_green = flood_r[1];
  assign out_flood_red   = flood_r[2];

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  // An empty output register leaves room all the way back to the input.
  `ECR_CHECK_IMPLY(a_empty_out_takes_input, !vld_r[NSTG-1], !in_stall)
  // An accepted item lands in the first stage.
  `ECR_CHECK_NEXT(a_accept_lands, in_valid && !in_stall, vld_r[0])
  // Clamp leaves the dividend below the divisor for a live segment.
  `ECR_CHECK_IMPLY(a_clamp_below_span, vld_r[2] && !st_r[0].flat, st_r[0].rem < st_r[0].dvs)
  // The remainder stays below the divisor through the last step.
  `ECR_CHECK_IMPLY(a_div_rem_bound, vld_r[NSTG-2] && !st_r[FB].flat,
                   st_r[FB].rem < st_r[FB].dvs)

endmodule

// ----- sim/ramp_checker.sv -----
// Scoreboard for the elevation color ramp: watches the config, pixel and color channels.
// Predicts each accepted pixel's heat and flood colors and compares them in order.
// Depends on ecr_pkg.
module ramp_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic signed [ecr_pkg::DZ_W-1:0]  in_elevation,
  input  logic                             in_in_grid,
  input  logic [ecr_pkg::CH_W-1:0]         in_src_blue,
  input  logic [ecr_pkg::CH_W-1:0]         in_src_green,
  input  logic [ecr_pkg::CH_W-1:0]         in_src_red,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [ecr_pkg::CH_W-1:0]         out_heat_blue,
  input  logic [ecr_pkg::CH_W-1:0]         out_heat_green,
  input  logic [ecr_pkg::CH_W-1:0]         out_heat_red,
  input  logic [ecr_pkg::CH_W-1:0]         out_flood_blue,
  input  logic [ecr_pkg::CH_W-1:0]         out_flood_green,
  input  logic [ecr_pkg::CH_W-1:0]         out_flood_red,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [ecr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ecr_pkg::KNOT_W-1:0]       cfg_data,
  output int                               mismatches,
  output int                               in_flight
);
  timeunit 1ns;
  timeprecision 1ps;
  import ecr_pkg::*;

  // Index 0..2: heat blue, green, red; 3..5: flood blue, green, red.
  typedef logic [5:0][CH_W-1:0] pixel_colors_t;

  string field_name [6] = '{"heat_blue", "heat_green", "heat_red",
                            "flood_blue", "flood_green", "flood_red"};

  logic [KCNT_W-1:0]        ramp_count;
  logic [KNOT_W-1:0]        ramp_knot [KNOT_SLOTS];
  logic signed [DZ_W-1:0]   fallback_dz;

  pixel_colors_t colors_due [$];
  int fail_count = 0;
  int results_seen = 0;

  assign mismatches = fail_count;

  task automatic flag_mismatch(string what);
    fail_count++;
    $display("[%0t] ramp_checker: result %0d: %s", $time, results_seen, what);
  endtask

  function automatic longint knot_level(int i);
    return longint'($signed(ramp_knot[i][KNOT_W-1 -: ELEV_W]));
  endfunction

  function automatic logic [CH_W-1:0] flood_tint(logic [CH_W-1:0] c, bit on);
    if (on && ({1'b0, c} + FLOOD_ADD) < CHAN_LIMIT)
      return c + FLOOD_ADD[CH_W-1:0];
    return c;
  endfunction

  function automatic pixel_colors_t color_pixel(logic signed [DZ_W-1:0] elev, logic grid,
                                                logic [CH_W-1:0] sb, logic [CH_W-1:0] sg,
                                                logic [CH_W-1:0] sr);
    logic signed [DZ_W-1:0] dz;
    longint z, e_lo, span, off, frac, one;
    int used, last, seg;
    logic [KNOT_W-1:0] ka, kb;
    bit tint_b, tint_g, tint_r;
    pixel_colors_t pc;
    dz = grid ? elev : fallback_dz;
    z = longint'(dz) * 16;
    used = int'(ramp_count);
    if (used < 2) used = 2;
    if (used > MAX_KNOTS) used = MAX_KNOTS;
    last = used - 1;
    one = longint'(1) << FRAC_BITS;
    frac = 0;
    if (z < knot_level(0)) begin
      ka = ramp_knot[0];
      kb = ka;
    end else if (z >= knot_level(last)) begin
      ka = ramp_knot[last];
      kb = ka;
    end else begin
      // first segment whose upper knot lies above z
      seg = last - 1;
      for (int x = last - 1; x >= 0; x--)
        if (z < knot_level(x + 1)) seg = x;
      e_lo = knot_level(seg);
      span = knot_level(seg + 1) - e_lo;
      off = z - e_lo;
      if (off < 0) off = 0;
      if (span > 0) begin
        if (off >= span) off = span - 1;
        frac = (off << FRAC_BITS) / span;
      end
      ka = ramp_knot[seg];
      kb = ramp_knot[seg + 1];
    end
    for (int c = 0; c < 3; c++)
      pc[c] = CH_W'((longint'(ka[CH_W*c +: CH_W]) * (one - frac) +
                     longint'(kb[CH_W*c +: CH_W]) * frac) >> FRAC_BITS);
    tint_b = dz < FLOOD_BLUE_BELOW;
    tint_g = !tint_b && dz < FLOOD_GREEN_BELOW;
    tint_r = !tint_b && !tint_g && dz < FLOOD_RED_BELOW;
    pc[3] = flood_tint(sb, tint_b);
    pc[4] = flood_tint(sg, tint_g);
    pc[5] = flood_tint(sr, tint_r);
    return pc;
  endfunction

  always @(posedge clk) begin
    pixel_colors_t got, want;
    if (!rst_n) begin
      ramp_count = KNOT_COUNT_RESET;
      for (int i = 0; i < KNOT_SLOTS; i++) ramp_knot[i] = '0;
      fallback_dz = FALLBACK_RESET;
      colors_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KNOT_COUNT: ramp_count = cfg_data[KCNT_W-1:0];
          REG_KNOT_0, REG_KNOT_1, REG_KNOT_2, REG_KNOT_3, REG_KNOT_4, REG_KNOT_5:
            ramp_knot[int'(cfg_index) - int'(REG_KNOT_0)] = cfg_data;
          REG_FALLBACK:   fallback_dz = cfg_data[DZ_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (colors_due.size() == 0) begin
          flag_mismatch("color item with no pixel pending");
        end else begin
          want = colors_due.pop_front();
          got = {out_flood_red, out_flood_green, out_flood_blue,
                 out_heat_red, out_heat_green, out_heat_blue};
          for (int f = 0; f < 6; f++)
            if (got[f] !== want[f])
              flag_mismatch($sformatf("%s got %0d want %0d", field_name[f], got[f], want[f]));
        end
      end
      if (in_valid && !in_stall)
        colors_due = {colors_due, color_pixel(in_elevation, in_in_grid,
                                              in_src_blue, in_src_green, in_src_red)};
    end
    in_flight <= colors_due.size();
  end

endmodule

// ----- sim/tb.sv -----
// Top of the elevation color ramp testbench: clock, reset, stimulus and verdict.
// Drives elevation_color_ramp and hands every channel to ramp_checker.
// Depends on ecr_pkg, elevation_color_ramp and ramp_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ecr_pkg::*;

  localparam int RESET_CYCLES = 11;
  localparam int LIMIT_CYCLES = 400000;
  localparam int LONG_HOLD    = 60;   // receiver hold-off, far above the pipe depth
  localparam int DRAIN_TAIL   = 40;   // well above the pipe depth
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 70;
  localparam int STEADY_PHASE = 3;
  localparam int HOLD_PHASE   = 6;
  localparam int DZ_MIN       = -32768;
  localparam int DZ_MAX       = 32767;
  localparam int ELEV_MIN     = -(1 << (ELEV_W - 1));
  localparam int ELEV_MAX     = (1 << (ELEV_W - 1)) - 1;

  typedef enum int {RAMP_NARROW, RAMP_WIDE, RAMP_FULL, RAMP_DISORDERED} ramp_kind_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                    in_valid;
  logic                    in_stall;
  logic signed [DZ_W-1:0]  in_elevation;
  logic                    in_in_grid;
  logic [CH_W-1:0]         in_src_blue, in_src_green, in_src_red;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [CH_W-1:0]         out_heat_blue, out_heat_green, out_heat_red;
  logic [CH_W-1:0]         out_flood_blue, out_flood_green, out_flood_red;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [KNOT_W-1:0]       cfg_data;

  int mismatches;
  int in_flight;
  int cycle_count;

  // Knot levels (Q16.4) last written, kept only to aim elevations at the ramp.
  int lvl [KNOT_SLOTS];
  int used_knots;

  // Pacing controls for the sender and for the receiver process.
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int hold_requests = 0;
  int holds_done = 0;
  bit rx_stalling = 1'b0;
  int rx_left = 0;

  int chan_corner [4] = '{0, 164, 165, 255};
  int fall_corner [8] = '{DZ_MIN, DZ_MAX, 9, 10, 49, 50, 99, 100};
  int probe_m [16] = '{DZ_MIN, -101, -100, -50, -1, 0, 9, 10, 25, 49, 50, 99, 100,
                       999, 1000, DZ_MAX};
  int phase_count [PHASES] = '{2, 3, 4, 5, 6, 0, 1, 7, 6, 3, 2, 6};
  ramp_kind_t phase_kind [PHASES] = '{RAMP_NARROW, RAMP_WIDE, RAMP_FULL, RAMP_NARROW,
                                      RAMP_DISORDERED, RAMP_WIDE, RAMP_NARROW, RAMP_FULL,
                                      RAMP_DISORDERED, RAMP_WIDE, RAMP_NARROW,
                                      RAMP_DISORDERED};

  elevation_color_ramp dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_elevation    (in_elevation),
    .in_in_grid      (in_in_grid),
    .in_src_blue     (in_src_blue),
    .in_src_green    (in_src_green),
    .in_src_red      (in_src_red),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_heat_blue   (out_heat_blue),
    .out_heat_green  (out_heat_green),
    .out_heat_red    (out_heat_red),
    .out_flood_blue  (out_flood_blue),
    .out_flood_green (out_flood_green),
    .out_flood_red   (out_flood_red),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  ramp_checker scoreboard (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_elevation    (in_elevation),
    .in_in_grid      (in_in_grid),
    .in_src_blue     (in_src_blue),
    .in_src_green    (in_src_green),
    .in_src_red      (in_src_red),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_heat_blue   (out_heat_blue),
    .out_heat_green  (out_heat_green),
    .out_heat_red    (out_heat_red),
    .out_flood_blue  (out_flood_blue),
    .out_flood_green (out_flood_green),
    .out_flood_red   (out_flood_red),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .in_flight       (in_flight)
  );

  // 12 ns clock: low half first, then high half.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int idle_len();
    if ($urandom_range(0, 99) < 85) return int'($urandom_range(1, 3));
    return int'($urandom_range(12, 40));
  endfunction

  // Receiver: decide out_stall once per falling edge. A hold-off request
  // preempts the random pattern and holds stall high until its countdown in
  // rx_left runs out, while the sender keeps offering pixels.
  always @(negedge clk) begin
    if (holds_done != hold_requests) begin
      holds_done++;
      rx_stalling = 1'b1;
      rx_left = LONG_HOLD;
    end else if (rx_left == 0) begin
      if (rx_steady) begin
        rx_stalling = 1'b0;
        rx_left = 1;
      end else begin
        rx_stalling = !rx_stalling;
        rx_left = rx_stalling ? idle_len() : int'($urandom_range(1, 24));
      end
    end
    rx_left--;
    out_stall <= rx_stalling;
  end

  // Watchdog: end the run as failed if it has not finished by the limit.
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb NOT OK");
    $finish;
  end

  function automatic logic [KNOT_W-1:0] pack_knot(int level, logic [23:0] rgb);
    return {level[ELEV_W-1:0], rgb};
  endfunction

  // Write one register; hold the request until the port takes it, then drop it.
  task automatic write_reg(cfg_reg_t idx, logic [KNOT_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Offer one pixel and wait until it is accepted. Leave in_valid high so a
  // back-to-back pixel follows without a bubble.
  task automatic send_pixel(int elev, bit grid, int b, int g, int r);
    @(negedge clk);
    in_valid     <= 1'b1;
    in_elevation <= DZ_W'(elev);
    in_in_grid   <= grid;
    in_src_blue  <= CH_W'(b);
    in_src_green <= CH_W'(g);
    in_src_red   <= CH_W'(r);
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid for a random stretch, or not at all most of the time.
  task automatic sender_gap();
    int gap;
    gap = ($urandom_range(0, 99) < 60) ? 0 : idle_len();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Stop offering and wait until every pixel sent has come back as colors.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (in_flight != 0) @(negedge clk);
  endtask

  // Write a full ramp: count (with junk above its field), all six knots and
  // the fallback elevation (junk above 16 bits as well).
  task automatic load_ramp(int count_code, ramp_kind_t kind, int fall_m);
    int e;
    logic [23:0] rgb;
    logic [KNOT_W-1:0] word;
    used_knots = (count_code < 2) ? 2 : (count_code > MAX_KNOTS) ? MAX_KNOTS : count_code;
    word = KNOT_W'({$urandom, $urandom});
    word[KCNT_W-1:0] = count_code[KCNT_W-1:0];
    write_reg(REG_KNOT_COUNT, word);
    case (kind)
      RAMP_NARROW: e = (int'($urandom_range(0, 2500)) - 1250) * 16;
      RAMP_WIDE:   e = int'($urandom_range(0, 500000)) - 600000;
      default:     e = 0;
    endcase
    for (int i = 0; i < KNOT_SLOTS; i++) begin
      case (kind)
        RAMP_NARROW: if (i > 0) e = e + int'($urandom_range(1, 25)) * 16;
        RAMP_WIDE:   if (i > 0) e = e + int'($urandom_range(1, 120000));
        RAMP_FULL:
          e = (i < used_knots) ? ELEV_MIN + (i * (ELEV_MAX - ELEV_MIN)) / (used_knots - 1)
                               : ELEV_MAX;
        default:
          // repeats and reversals: zero and negative spans
          if (i == 0 || $urandom_range(0, 3) != 0) e = int'($urandom_range(0, 80000)) - 40000;
      endcase
      if (e > ELEV_MAX) e = ELEV_MAX;
      case ($urandom_range(0, 9))
        0:       rgb = 24'h000000;
        1:       rgb = 24'hFFFFFF;
        default: rgb = 24'($urandom);
      endcase
      lvl[i] = e;
      write_reg(cfg_reg_t'(int'(REG_KNOT_0) + i), pack_knot(e, rgb));
    end
    word = KNOT_W'({$urandom, $urandom});
    word[DZ_W-1:0] = fall_m[DZ_W-1:0];
    write_reg(REG_FALLBACK, word);
  endtask

  // Aim most elevations at the knots or between the ends of the ramp.
  function automatic int pick_elevation();
    int k, v, lo, hi;
    lo = lvl[0] >>> 4;
    hi = lvl[used_knots - 1] >>> 4;
    if (lo > hi) begin
      k = lo;
      lo = hi;
      hi = k;
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        k = int'($urandom_range(0, used_knots - 1));
        v = (lvl[k] >>> 4) + int'($urandom_range(0, 6)) - 3;
      end
      4, 5, 6: v = lo + int'($urandom_range(0, hi - lo));
      default: v = int'($urandom_range(0, 65535)) + DZ_MIN;
    endcase
    if (v < DZ_MIN) v = DZ_MIN;
    if (v > DZ_MAX) v = DZ_MAX;
    return v;
  endfunction

  // Source channel: tint boundaries and extremes often, random otherwise.
  function automatic int pick_channel();
    if ($urandom_range(0, 3) == 0) return chan_corner[$urandom_range(0, 3)];
    return int'($urandom_range(0, 255));
  endfunction

  function automatic int pick_fallback();
    if ($urandom_range(0, 2) == 0) return fall_corner[$urandom_range(0, 7)];
    return int'($urandom_range(0, 65535)) + DZ_MIN;
  endfunction

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_elevation = '0;
    in_in_grid   = 1'b0;
    in_src_blue  = '0;
    in_src_green = '0;
    in_src_red   = '0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_KNOT_COUNT;
    cfg_data     = '0;
    used_knots   = 6;
    for (int i = 0; i < KNOT_SLOTS; i++) lvl[i] = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset ramp: all knots at zero, so below zero clamps low and the rest
    // clamps to the last knot. Invalid sample picks up the -10 fallback
    // (blue tint), then the blue tint just under and right at the cap.
    send_pixel(DZ_MIN, 1'b1, 0, 0, 0);
    send_pixel(DZ_MAX, 1'b1, 255, 255, 255);
    send_pixel(5, 1'b0, 164, 165, 0);
    send_pixel(3, 1'b1, 165, 164, 255);
    drain();

    // Four-knot ramp at -100, 0, 50 and 1000 m; the two spare knots carry
    // junk that must stay unused. Fallback 20 lands in the green band.
    write_reg(REG_KNOT_COUNT, KNOT_W'(4));
    write_reg(REG_KNOT_0, pack_knot(-1600, 24'h102030));
    write_reg(REG_KNOT_1, pack_knot(0, 24'hFF0080));
    write_reg(REG_KNOT_2, pack_knot(800, 24'h00FF40));
    write_reg(REG_KNOT_3, pack_knot(16000, 24'hFFFFFF));
    write_reg(REG_KNOT_4, pack_knot(-5, 24'h5A5A5A));
    write_reg(REG_KNOT_5, pack_knot(ELEV_MAX, 24'hA5A5A5));
    write_reg(REG_FALLBACK, KNOT_W'(20));
    // Walk below, onto every knot, between knots, across every tint
    // threshold and past the last knot.
    for (int i = 0; i < 16; i++)
      send_pixel(probe_m[i], 1'b1, chan_corner[i % 4], chan_corner[(i + 1) % 4],
                 chan_corner[(i + 2) % 4]);
    send_pixel(DZ_MAX, 1'b0, 164, 164, 164);
    drain();

    // Fallback extremes.
    write_reg(REG_FALLBACK, KNOT_W'(16'h8000));
    send_pixel(0, 1'b0, 164, 10, 200);
    drain();
    write_reg(REG_FALLBACK, KNOT_W'(16'h7FFF));
    send_pixel(-7, 1'b0, 1, 2, 3);

    // Random phases. Each one drains first, so the sender also pauses
    // until every color has arrived, then loads a fresh ramp.
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      load_ramp(phase_count[ph], phase_kind[ph], pick_fallback());
      tx_steady = (ph == STEADY_PHASE) || (ph == HOLD_PHASE);
      rx_steady = (ph == STEADY_PHASE);
      // Fill the pipe against a held-off receiver until the input stalls.
      if (ph == HOLD_PHASE) hold_requests++;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_pixel(pick_elevation(), $urandom_range(0, 4) != 0,
                   pick_channel(), pick_channel(), pick_channel());
        if (!tx_steady) sender_gap();
      end
    end

    drain();
    // Watch a little longer for stray color items.
    repeat (DRAIN_TAIL) @(negedge clk);
    if (mismatches == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
